// ----- rtl/lsag_pkg.sv -----
// Shared types and constants of the limit-switch axis guard.
// No dependencies; every other file of the block imports this package.
package lsag_pkg;

  // Item field widths
  localparam int SwitchCount = 4;
  localparam int PosWidth    = 32;
  localparam int ThrWidth    = 16;
  localparam int CntWidth    = 17;
  localparam logic [CntWidth-1:0] CntMax = {CntWidth{1'b1}};

  // Configuration port
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 32;

  localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE_COUNT = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_UPPER_SOFT_A2  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_LOWER_SOFT_A2  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_UPPER_SOFT_A0  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_LOWER_SOFT_A0  = 3'd4;

  // Register reset values
  localparam logic [ThrWidth-1:0]        RST_DEBOUNCE_COUNT = 16'd1000;
  localparam logic signed [PosWidth-1:0] RST_UPPER_SOFT_A2  = 32'sd101000000;
  localparam logic signed [PosWidth-1:0] RST_LOWER_SOFT_A2  = -32'sd38000000;
  localparam logic signed [PosWidth-1:0] RST_UPPER_SOFT_A0  = 32'sd73000000;
  localparam logic signed [PosWidth-1:0] RST_LOWER_SOFT_A0  = -32'sd63000000;

  // Switch bit positions
  localparam int SW_NEG_A2  = 0;
  localparam int SW_NEG_A01 = 1;
  localparam int SW_POS_A2  = 2;
  localparam int SW_POS_A01 = 3;

  // Configuration register set
  typedef struct packed {
    logic [ThrWidth-1:0]        debounce_count;
    logic signed [PosWidth-1:0] upper_soft_a2;
    logic signed [PosWidth-1:0] lower_soft_a2;
    logic signed [PosWidth-1:0] upper_soft_a0;
    logic signed [PosWidth-1:0] lower_soft_a0;
  } lsag_cfg_t;

  // Which guards act on one axis in the current item
  typedef struct packed {
    logic hard_neg;
    logic hard_pos;
    logic soft_en;
  } lsag_guard_t;

endpackage

// ----- rtl/lsag_intf.sv -----
// Valid/ready channel interfaces for input and result items.
// Depends on lsag_pkg for field widths.
interface lsag_in_if
  import lsag_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [SwitchCount-1:0]     switch_bits;
  logic signed [PosWidth-1:0] setpoint_a0;
  logic signed [PosWidth-1:0] position_a0;
  logic signed [PosWidth-1:0] setpoint_a1;
  logic signed [PosWidth-1:0] position_a1;
  logic signed [PosWidth-1:0] setpoint_a2;
  logic signed [PosWidth-1:0] position_a2;
  logic                       homing_a0;
  logic                       homing_a2;
  logic                       homed_a0;
  logic                       homed_a2;

  modport source (
    output valid, switch_bits, setpoint_a0, position_a0, setpoint_a1, position_a1,
           setpoint_a2, position_a2, homing_a0, homing_a2, homed_a0, homed_a2,
    input  ready
  );
  modport sink (
    input  valid, switch_bits, setpoint_a0, position_a0, setpoint_a1, position_a1,
           setpoint_a2, position_a2, homing_a0, homing_a2, homed_a0, homed_a2,
    output ready
  );
endinterface

interface lsag_out_if
  import lsag_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [PosWidth-1:0] new_setpoint_a0;
  logic signed [PosWidth-1:0] new_setpoint_a1;
  logic signed [PosWidth-1:0] new_setpoint_a2;
  logic                       stop_a0;
  logic                       stop_a1;
  logic                       stop_a2;
  logic [SwitchCount-1:0]     limit_flags;

  modport source (
    output valid, new_setpoint_a0, new_setpoint_a1, new_setpoint_a2,
           stop_a0, stop_a1, stop_a2, limit_flags,
    input  ready
  );
  modport sink (
    input  valid, new_setpoint_a0, new_setpoint_a1, new_setpoint_a2,
           stop_a0, stop_a1, stop_a2, limit_flags,
    output ready
  );
endinterface

// ----- rtl/lsag_cfg_regs.sv -----
// Configuration registers of the guard: debounce threshold and soft limits.
// Depends on lsag_pkg.
module lsag_cfg_regs
  import lsag_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output lsag_cfg_t               cfg
);

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_count <= RST_DEBOUNCE_COUNT;
      cfg.upper_soft_a2  <= RST_UPPER_SOFT_A2;
      cfg.lower_soft_a2  <= RST_LOWER_SOFT_A2;
      cfg.upper_soft_a0  <= RST_UPPER_SOFT_A0;
      cfg.lower_soft_a0  <= RST_LOWER_SOFT_A0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_COUNT: cfg.debounce_count <= cfg_data[ThrWidth-1:0];
        CFG_UPPER_SOFT_A2:  cfg.upper_soft_a2  <= cfg_data[PosWidth-1:0];
        CFG_LOWER_SOFT_A2:  cfg.lower_soft_a2  <= cfg_data[PosWidth-1:0];
        CFG_UPPER_SOFT_A0:  cfg.upper_soft_a0  <= cfg_data[PosWidth-1:0];
        CFG_LOWER_SOFT_A0:  cfg.lower_soft_a0  <= cfg_data[PosWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/lsag_debounce.sv -----
// Per-switch debounce counters and flags, advanced once per processed item.
// Depends on lsag_pkg.
module lsag_debounce
  import lsag_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [SwitchCount-1:0] bits,
  input  logic [ThrWidth-1:0]    threshold,
  output logic [SwitchCount-1:0] flags_next
);

  logic [CntWidth-1:0]    cnt [SwitchCount];
  logic [CntWidth-1:0]    cnt_next [SwitchCount];
  logic [SwitchCount-1:0] flag;

  // Saturating count while high; a low bit clears count and flag
  always_comb begin
    for (int i = 0; i < SwitchCount; i++) begin
      if (bits[i]) begin
        cnt_next[i]   = (cnt[i] == CntMax) ? cnt[i] : cnt[i] + 1'b1;
        flags_next[i] = flag[i] | (cnt_next[i] == {1'b0, threshold});
      end else begin
        cnt_next[i]   = '0;
        flags_next[i] = 1'b0;
      end
    end
  end

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SwitchCount; i++) begin
        cnt[i] <= '0;
      end
      flag <= '0;
    end else if (step) begin
      for (int i = 0; i < SwitchCount; i++) begin
        cnt[i] <= cnt_next[i];
      end
      flag <= flags_next;
    end
  end

endmodule

// ----- rtl/lsag_axis_clamp.sv -----
// Hard and soft limit clamp of one axis setpoint to its measured position.
// Depends on lsag_pkg.
module lsag_axis_clamp
  import lsag_pkg::*;
(
  input  lsag_guard_t                guard,
  input  logic signed [PosWidth-1:0] setpoint,
  input  logic signed [PosWidth-1:0] position,
  input  logic signed [PosWidth-1:0] upper_limit,
  input  logic signed [PosWidth-1:0] lower_limit,
  output logic signed [PosWidth-1:0] new_setpoint,
  output logic                       stop
);

  logic neg_active;
  logic pos_active;

  // Once clamped the setpoint equals the position, so later checks never fire:
  // the checks reduce to one OR over the original setpoint.
  always_comb begin
    neg_active   = guard.hard_neg | (guard.soft_en & (position < lower_limit));
    pos_active   = guard.hard_pos | (guard.soft_en & (position > upper_limit));
    stop         = (neg_active & (setpoint < position)) |
                   (pos_active & (setpoint > position));
    new_setpoint = stop ? position : setpoint;
  end

endmodule

// ----- rtl/limit_switch_axis_guard_top.sv -----
// Limit-switch axis guard top level: input register, debounce, clamps, result register.
// Depends on lsag_pkg, lsag_intf, lsag_cfg_regs, lsag_debounce, lsag_axis_clamp.
//
// Usage:
//   in_item  - valid/ready channel, one control tick per item: raw switch bits,
//              setpoint and position of three axes, homing and homed bits.
//   out_item - valid/ready channel, one result per tick: the three setpoints,
//              clamped where a limit is active, a stop bit per axis and the
//              debounced switch flags.
//   cfg_we / cfg_index / cfg_data - register writes, to be made only while idle; the block does not enforce it.
// The item is held in an input register, debounced and clamped in one shallow
// pass, and caught in the result register. One item is accepted every cycle
// while the receiver does not stall; the rate is set by the single compare-and-select
// pass between those two registers.
// Reset clears the debounce counters and flags, empties both registers and
// loads the registers with their default threshold and soft limits.
// When the receiver stalls the result register holds, the input register
// fills behind it, and then in_item.ready drops until out_item drains.
module limit_switch_axis_guard_top
  import lsag_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  lsag_in_if.sink                 in_item,
  lsag_out_if.source              out_item,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  lsag_cfg_t cfg;

  // Input register
  logic                       in_valid;
  logic [SwitchCount-1:0]     in_bits;
  logic signed [PosWidth-1:0] in_sp0, in_pos0, in_sp1, in_pos1, in_sp2, in_pos2;
  logic                       in_homing0, in_homing2, in_homed0, in_homed2;

  logic out_free;
  logic advance;
  logic take;

  logic [SwitchCount-1:0]     flags_next;
  lsag_guard_t                guard0, guard1, guard2;
  logic signed [PosWidth-1:0] sp0_c, sp1_c, sp2_c;
  logic                       stop0_c, stop1_c, stop2_c;

  // Handshake: the result register frees when taken, the input register when moved on
  assign out_free      = ~out_item.valid | out_item.ready;
  assign advance       = in_valid & out_free;
  assign in_item.ready = ~in_valid | advance;
  assign take          = in_item.valid & in_item.ready;

  lsag_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_item.ready) begin
      in_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_bits    <= in_item.switch_bits;
      in_sp0     <= in_item.setpoint_a0;
      in_pos0    <= in_item.position_a0;
      in_sp1     <= in_item.setpoint_a1;
      in_pos1    <= in_item.position_a1;
      in_sp2     <= in_item.setpoint_a2;
      in_pos2    <= in_item.position_a2;
      in_homing0 <= in_item.homing_a0;
      in_homing2 <= in_item.homing_a2;
      in_homed0  <= in_item.homed_a0;
      in_homed2  <= in_item.homed_a2;
    end
  end

  // Debounce advances as each item moves into the result register
  lsag_debounce u_debounce (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .bits       (in_bits),
    .threshold  (cfg.debounce_count),
    .flags_next (flags_next)
  );

  // Guard selection: axis one follows axis zero's switches, no soft limits
  always_comb begin
    guard0.hard_neg = flags_next[SW_NEG_A01] & ~in_homing0;
    guard0.hard_pos = flags_next[SW_POS_A01] & ~in_homing0;
    guard0.soft_en  = in_homed0 & ~in_homing0;
    guard1.hard_neg = guard0.hard_neg;
    guard1.hard_pos = guard0.hard_pos;
    guard1.soft_en  = 1'b0;
    guard2.hard_neg = flags_next[SW_NEG_A2] & ~in_homing2;
    guard2.hard_pos = flags_next[SW_POS_A2] & ~in_homing2;
    guard2.soft_en  = in_homed2 & ~in_homing2;
  end

  lsag_axis_clamp u_clamp_a0 (
    .guard        (guard0),
    .setpoint     (in_sp0),
    .position     (in_pos0),
    .upper_limit  (cfg.upper_soft_a0),
    .lower_limit  (cfg.lower_soft_a0),
    .new_setpoint (sp0_c),
    .stop         (stop0_c)
  );

  lsag_axis_clamp u_clamp_a1 (
    .guard        (guard1),
    .setpoint     (in_sp1),
    .position     (in_pos1),
    .upper_limit  (cfg.upper_soft_a0),
    .lower_limit  (cfg.lower_soft_a0),
    .new_setpoint (sp1_c),
    .stop         (stop1_c)
  );

  lsag_axis_clamp u_clamp_a2 (
    .guard        (guard2),
    .setpoint     (in_sp2),
    .position     (in_pos2),
    .upper_limit  (cfg.upper_soft_a2),
    .lower_limit  (cfg.lower_soft_a2),
    .new_setpoint (sp2_c),
    .stop         (stop2_c)
  );

  // Result register control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (out_free) begin
      out_item.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.new_setpoint_a0 <= sp0_c;
      out_item.new_setpoint_a1 <= sp1_c;
      out_item.new_setpoint_a2 <= sp2_c;
      out_item.stop_a0         <= stop0_c;
      out_item.stop_a1         <= stop1_c;
      out_item.stop_a2         <= stop2_c;
      out_item.limit_flags     <= flags_next;
    end
  end

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for limit_switch_axis_guard_top: a directed table of ticks, then
// random register settings and switch/position streams, scored against a local model.
// Depends on lsag_pkg, lsag_in_if / lsag_out_if and the guard top level.
module tb;
  import lsag_pkg::*;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic [CntWidth-1:0] CNT_SAT = 17'h1_FFFF;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_TICKS   = 90;
  localparam int HOLD_TICKS    = 50;
  localparam int DRAIN_CYCLES  = 20;

  typedef logic signed [PosWidth-1:0] pos_t;

  // One control tick as driven on in_item
  typedef struct packed {
    logic [SwitchCount-1:0] sw;
    pos_t sp0;
    pos_t pos0;
    pos_t sp1;
    pos_t pos1;
    pos_t sp2;
    pos_t pos2;
    logic homing0;
    logic homing2;
    logic homed0;
    logic homed2;
  } tick_t;

  // One guard result as seen on out_item
  typedef struct packed {
    pos_t sp0;
    pos_t sp1;
    pos_t sp2;
    logic stop0;
    logic stop1;
    logic stop2;
    logic [SwitchCount-1:0] flags;
  } guard_res_t;

  // Directed table row: either a register write or a tick, the latter
  // with an optional hand-typed result
  typedef struct packed {
    logic is_cfg;
    logic [CfgIdxWidth-1:0] idx;
    logic [CfgDataWidth-1:0] data;
    logic typed;
    tick_t t;
    guard_res_t r;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  lsag_in_if  in_if ();
  lsag_out_if out_if ();

  limit_switch_axis_guard_top u_top (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_if),
    .out_item (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Local copy of the registers and debounce state
  logic [ThrWidth-1:0]    thr;
  pos_t                   up_a2, lo_a2, up_a0, lo_a0;
  logic [CntWidth-1:0]    sw_count [SwitchCount];
  logic [SwitchCount-1:0] sw_flag;

  guard_res_t guard_due_q[$];
  plan_row_t  plan[$];
  int mism, n_ticks, n_flagged, n_stopped, n_writes, cycles;
  bit gaps_on;
  logic [SwitchCount-1:0] held_sw;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Debounce, then hard limits, then soft limits, for one tick
  function automatic guard_res_t predict_guard(tick_t t);
    guard_res_t r;
    pos_t p0, p1, p2;
    int i;
    r = '0;
    r.sp0 = t.sp0;
    r.sp1 = t.sp1;
    r.sp2 = t.sp2;
    p0 = t.pos0;
    p1 = t.pos1;
    p2 = t.pos2;
    for (i = 0; i < SwitchCount; i++) begin
      if (t.sw[i]) begin
        if (sw_count[i] != CNT_SAT) sw_count[i] = sw_count[i] + 1'b1;
        if (sw_count[i] == {1'b0, thr}) sw_flag[i] = 1'b1;
      end else begin
        sw_count[i] = '0;
        sw_flag[i]  = 1'b0;
      end
    end
    r.flags = sw_flag;
    // hard limits; axis 1 shares the axis 0 switches and homing bit
    if (sw_flag[SW_NEG_A01] && !t.homing0) begin
      if (r.sp0 < p0) begin r.sp0 = p0; r.stop0 = 1'b1; end
      if (r.sp1 < p1) begin r.sp1 = p1; r.stop1 = 1'b1; end
    end
    if (sw_flag[SW_POS_A01] && !t.homing0) begin
      if (r.sp0 > p0) begin r.sp0 = p0; r.stop0 = 1'b1; end
      if (r.sp1 > p1) begin r.sp1 = p1; r.stop1 = 1'b1; end
    end
    if (sw_flag[SW_NEG_A2] && !t.homing2) begin
      if (r.sp2 < p2) begin r.sp2 = p2; r.stop2 = 1'b1; end
    end
    if (sw_flag[SW_POS_A2] && !t.homing2) begin
      if (r.sp2 > p2) begin r.sp2 = p2; r.stop2 = 1'b1; end
    end
    // soft limits, only once homed and not homing; both sides checked
    if (t.homed2 && !t.homing2) begin
      if (p2 > up_a2 && r.sp2 > p2) begin r.sp2 = p2; r.stop2 = 1'b1; end
      if (p2 < lo_a2 && r.sp2 < p2) begin r.sp2 = p2; r.stop2 = 1'b1; end
    end
    if (t.homed0 && !t.homing0) begin
      if (p0 > up_a0 && r.sp0 > p0) begin r.sp0 = p0; r.stop0 = 1'b1; end
      if (p0 < lo_a0 && r.sp0 < p0) begin r.sp0 = p0; r.stop0 = 1'b1; end
    end
    return r;
  endfunction

  // Table helpers
  function automatic tick_t tk(logic [SwitchCount-1:0] sw, pos_t sp0, pos_t pos0,
                               pos_t sp1, pos_t pos1, pos_t sp2, pos_t pos2,
                               logic hg0, logic hg2, logic hd0, logic hd2);
    tick_t t;
    t = '{sw, sp0, pos0, sp1, pos1, sp2, pos2, hg0, hg2, hd0, hd2};
    return t;
  endfunction

  function automatic guard_res_t rs(pos_t sp0, pos_t sp1, pos_t sp2,
                                    logic s0, logic s1, logic s2,
                                    logic [SwitchCount-1:0] fl);
    guard_res_t r;
    r = '{sp0, sp1, sp2, s0, s1, s2, fl};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CfgIdxWidth-1:0] idx,
                                        logic [CfgDataWidth-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  function automatic plan_row_t tick_row(tick_t t);
    plan_row_t row;
    row = '0;
    row.t = t;
    return row;
  endfunction

  function automatic plan_row_t fixed_row(tick_t t, guard_res_t r);
    plan_row_t row;
    row = '0;
    row.typed = 1'b1;
    row.t     = t;
    row.r     = r;
    return row;
  endfunction

  // Random value pickers, biased towards the limits
  function automatic pos_t nudge(pos_t v);
    pos_t d;
    d = pos_t'($urandom_range(4));
    return v + d - 32'sd2;
  endfunction

  function automatic pos_t pick_pos(pos_t up, pos_t lo);
    case ($urandom_range(9))
      0, 1, 2: return nudge(up);
      3, 4, 5: return nudge(lo);
      6:       return $urandom_range(1) ? S32_MAX : S32_MIN;
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic pos_t pick_sp(pos_t pos);
    case ($urandom_range(7))
      0, 1, 2, 3: return nudge(pos);
      4:          return $urandom_range(1) ? S32_MAX : S32_MIN;
      default:    return pos_t'($urandom);
    endcase
  endfunction

  function automatic logic [ThrWidth-1:0] pick_thr();
    case ($urandom_range(7))
      0:       return '0;
      1, 2:    return ThrWidth'(1);
      3:       return ThrWidth'($urandom_range(4, 2));
      4, 5:    return ThrWidth'($urandom_range(12, 5));
      default: return ThrWidth'($urandom_range(40, 13));
    endcase
  endfunction

  function automatic void pick_limits(output pos_t up, output pos_t lo);
    case ($urandom_range(4))
      0: begin up = S32_MAX; lo = S32_MIN; end
      // inverted window: both sides may bite
      1: begin
        up = -pos_t'($urandom_range(1000));
        lo = pos_t'($urandom_range(1000));
      end
      2: begin up = pos_t'($urandom); lo = pos_t'($urandom); end
      default: begin
        up = pos_t'($urandom_range(200_000_000));
        lo = -pos_t'($urandom_range(200_000_000));
      end
    endcase
  endfunction

  function automatic tick_t rand_tick(logic [SwitchCount-1:0] sw);
    tick_t t;
    t.sw      = sw;
    t.pos0    = pick_pos(up_a0, lo_a0);
    t.sp0     = pick_sp(t.pos0);
    t.pos1    = pick_pos(up_a0, lo_a0);
    t.sp1     = pick_sp(t.pos1);
    t.pos2    = pick_pos(up_a2, lo_a2);
    t.sp2     = pick_sp(t.pos2);
    t.homing0 = $urandom_range(99) < 15;
    t.homing2 = $urandom_range(99) < 15;
    t.homed0  = $urandom_range(99) < 80;
    t.homed2  = $urandom_range(99) < 80;
    return t;
  endfunction

  // Drop valid and wait until every pending result has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (guard_due_q.size() != 0) @(negedge clk);
  endtask

  // Register write while idle; entered and left at a falling edge
  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_DEBOUNCE_COUNT: thr   = data[ThrWidth-1:0];
      CFG_UPPER_SOFT_A2:  up_a2 = data;
      CFG_LOWER_SOFT_A2:  lo_a2 = data;
      CFG_UPPER_SOFT_A0:  up_a0 = data;
      CFG_LOWER_SOFT_A0:  lo_a0 = data;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one tick, with random gaps ahead of it; queue its result on acceptance
  task automatic push_tick(tick_t t, logic typed, guard_res_t fixed);
    guard_res_t r;
    while (gaps_on && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.switch_bits <= t.sw;
    in_if.setpoint_a0 <= t.sp0;
    in_if.position_a0 <= t.pos0;
    in_if.setpoint_a1 <= t.sp1;
    in_if.position_a1 <= t.pos1;
    in_if.setpoint_a2 <= t.sp2;
    in_if.position_a2 <= t.pos2;
    in_if.homing_a0   <= t.homing0;
    in_if.homing_a2   <= t.homing2;
    in_if.homed_a0    <= t.homed0;
    in_if.homed_a2    <= t.homed2;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    r = predict_guard(t);
    guard_due_q.push_back(typed ? fixed : r);
    n_ticks++;
    @(negedge clk);
  endtask

  // Fresh register set, then a stream with long switch runs and some noise
  task automatic random_phase(int n);
    pos_t up, lo;
    logic [SwitchCount-1:0] sw;
    int i, b;
    write_reg(CFG_DEBOUNCE_COUNT, CfgDataWidth'(pick_thr()));
    pick_limits(up, lo);
    write_reg(CFG_UPPER_SOFT_A2, up);
    write_reg(CFG_LOWER_SOFT_A2, lo);
    pick_limits(up, lo);
    write_reg(CFG_UPPER_SOFT_A0, up);
    write_reg(CFG_LOWER_SOFT_A0, lo);
    for (i = 0; i < n; i++) begin
      for (b = 0; b < SwitchCount; b++) begin
        if ($urandom_range(99) < 6) held_sw[b] = ~held_sw[b];
      end
      sw = held_sw;
      if ($urandom_range(9) == 0) sw = SwitchCount'($urandom);
      push_tick(rand_tick(sw), 1'b0, '0);
    end
  endtask

  task automatic report(string why, guard_res_t want, guard_res_t got);
    mism++;
    if (mism <= 10) begin
      $display("mismatch %0d (%s) at cycle %0d:", mism, why, cycles);
      $display("  exp sp %0d %0d %0d stop %b%b%b flags %b", want.sp0, want.sp1, want.sp2,
               want.stop0, want.stop1, want.stop2, want.flags);
      $display("  got sp %0d %0d %0d stop %b%b%b flags %b", got.sp0, got.sp1, got.sp2,
               got.stop0, got.stop1, got.stop2, got.flags);
    end
  endtask

  // Receiver: random stalls while gaps are on
  always @(negedge clk) begin
    out_if.ready <= !gaps_on || ($urandom_range(99) >= 35);
  end

  // Score every accepted result against the oldest pending one
  always @(posedge clk) begin : score
    guard_res_t got, want;
    if (!rst && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.new_setpoint_a0, out_if.new_setpoint_a1, out_if.new_setpoint_a2,
              out_if.stop_a0, out_if.stop_a1, out_if.stop_a2, out_if.limit_flags};
      if (got.flags != '0) n_flagged++;
      if (got.stop0 || got.stop1 || got.stop2) n_stopped++;
      if (guard_due_q.size() == 0) begin
        report("no tick pending", '0, got);
      end else begin
        want = guard_due_q.pop_front();
        if (got !== want) report("field differs", want, got);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int k, p, i;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_if.valid       = 1'b0;
    in_if.switch_bits = '0;
    in_if.setpoint_a0 = '0;
    in_if.position_a0 = '0;
    in_if.setpoint_a1 = '0;
    in_if.position_a1 = '0;
    in_if.setpoint_a2 = '0;
    in_if.position_a2 = '0;
    in_if.homing_a0   = 1'b0;
    in_if.homing_a2   = 1'b0;
    in_if.homed_a0    = 1'b0;
    in_if.homed_a2    = 1'b0;
    out_if.ready      = 1'b0;
    gaps_on = 1'b1;
    held_sw = '0;
    mism = 0;
    n_ticks = 0;
    n_flagged = 0;
    n_stopped = 0;
    n_writes = 0;
    cycles = 0;
    // register and debounce state after reset
    thr   = 16'd1000;
    up_a2 = 101000000;
    lo_a2 = -38000000;
    up_a0 = 73000000;
    lo_a0 = -63000000;
    for (k = 0; k < SwitchCount; k++) sw_count[k] = '0;
    sw_flag = '0;

    // Directed table
    // defaults after reset: soft clamps at the window edges, extremes, homing
    plan.push_back(fixed_row(tk(4'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             rs(0, 0, 0, 0, 0, 0, 4'h0)));
    plan.push_back(fixed_row(tk(4'hF, S32_MAX, 73000001, S32_MIN, S32_MAX,
                                S32_MIN, -38000001, 0, 0, 1, 1),
                             rs(73000001, S32_MIN, -38000001, 1, 0, 1, 4'h0)));
    plan.push_back(fixed_row(tk(4'hF, S32_MAX, 73000001, S32_MIN, S32_MAX,
                                S32_MIN, -38000001, 1, 1, 1, 1),
                             rs(S32_MAX, S32_MIN, S32_MIN, 0, 0, 0, 4'h0)));
    // position exactly on a limit is not outside it
    plan.push_back(fixed_row(tk(4'hF, S32_MIN, -63000000, 5, -5, S32_MAX, 101000000,
                                0, 0, 1, 1),
                             rs(S32_MIN, 5, S32_MAX, 0, 0, 0, 4'h0)));
    plan.push_back(fixed_row(tk(4'h0, S32_MIN, S32_MIN, S32_MAX, S32_MIN,
                                S32_MAX, S32_MAX, 0, 0, 1, 1),
                             rs(S32_MIN, S32_MAX, S32_MAX, 0, 0, 0, 4'h0)));
    // count up past a threshold that is then lowered: the flag must stay clear
    plan.push_back(tick_row(tk(4'b0010, -100, 100, 3, 8, -4, 2, 0, 0, 1, 0)));
    plan.push_back(tick_row(tk(4'b0010, 100, -100, 8, 3, 2, -4, 0, 0, 0, 1)));
    plan.push_back(tick_row(tk(4'b0010, -100, 100, 3, 8, -4, 2, 1, 1, 1, 1)));
    plan.push_back(cfg_row(CFG_DEBOUNCE_COUNT, 32'd2));
    plan.push_back(fixed_row(tk(4'b0010, -100, 100, 0, 0, 0, 0, 0, 0, 0, 0),
                             rs(-100, 0, 0, 0, 0, 0, 4'h0)));
    // threshold of one: hard limits on every axis
    plan.push_back(cfg_row(CFG_DEBOUNCE_COUNT, 32'd1));
    plan.push_back(tick_row(tk(4'hF, -100, 100, 7, -7, -9, 9, 0, 0, 0, 0)));
    plan.push_back(fixed_row(tk(4'h0, 11, 22, 33, 44, 55, 66, 0, 0, 0, 0),
                             rs(11, 33, 55, 0, 0, 0, 4'h0)));
    plan.push_back(fixed_row(tk(4'hF, -100, 100, 7, -7, -9, 9, 0, 0, 0, 0),
                             rs(100, -7, 9, 1, 1, 1, 4'hF)));
    plan.push_back(fixed_row(tk(4'hF, -100, 100, 7, -7, 20, 9, 1, 0, 0, 0),
                             rs(-100, 7, 9, 0, 0, 1, 4'hF)));
    plan.push_back(fixed_row(tk(4'hF, 50, 10, -3, 3, 20, 9, 0, 1, 0, 0),
                             rs(10, 3, 20, 1, 1, 0, 4'hF)));
    plan.push_back(fixed_row(tk(4'hF, S32_MIN, S32_MIN, S32_MAX, S32_MAX, 0, 0,
                                0, 0, 1, 1),
                             rs(S32_MIN, S32_MAX, 0, 0, 0, 0, 4'hF)));
    // zero threshold never sets a flag
    plan.push_back(cfg_row(CFG_DEBOUNCE_COUNT, 32'd0));
    plan.push_back(fixed_row(tk(4'h0, 1, 2, 3, 4, 5, 6, 0, 0, 0, 0),
                             rs(1, 3, 5, 0, 0, 0, 4'h0)));
    plan.push_back(fixed_row(tk(4'hF, -100, 100, 7, -7, -9, 9, 0, 0, 0, 0),
                             rs(-100, 7, -9, 0, 0, 0, 4'h0)));
    plan.push_back(fixed_row(tk(4'hF, -100, 100, 7, -7, -9, 9, 0, 0, 0, 0),
                             rs(-100, 7, -9, 0, 0, 0, 4'h0)));
    // inverted window on axis 0, widest window on axis 2
    plan.push_back(cfg_row(CFG_UPPER_SOFT_A0, S32_MIN));
    plan.push_back(cfg_row(CFG_LOWER_SOFT_A0, S32_MAX));
    plan.push_back(cfg_row(CFG_UPPER_SOFT_A2, S32_MAX));
    plan.push_back(cfg_row(CFG_LOWER_SOFT_A2, S32_MIN));
    plan.push_back(fixed_row(tk(4'h0, 5, 0, 0, 0, S32_MIN, 0, 0, 0, 1, 1),
                             rs(0, 0, S32_MIN, 1, 0, 0, 4'h0)));
    plan.push_back(fixed_row(tk(4'h0, -5, 0, 0, 0, S32_MAX, S32_MAX, 0, 0, 1, 1),
                             rs(0, 0, S32_MAX, 1, 0, 0, 4'h0)));
    plan.push_back(fixed_row(tk(4'h0, -5, 0, 0, 0, 0, 0, 0, 0, 0, 1),
                             rs(-5, 0, 0, 0, 0, 0, 4'h0)));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].idx, plan[k].data);
      else push_tick(plan[k].t, plan[k].typed, plan[k].r);
    end

    // Random phases; midway, all switches held high at full rate with no
    // idling on either side, past a mid-sized threshold
    for (p = 0; p < RANDOM_PHASES; p++) begin
      random_phase(PHASE_TICKS);
      if (p == 3) begin
        write_reg(CFG_DEBOUNCE_COUNT, CfgDataWidth'(16'd32));
        gaps_on = 1'b0;
        held_sw = '1;
        for (i = 0; i < HOLD_TICKS; i++) push_tick(rand_tick(held_sw), 1'b0, '0);
        gaps_on = 1'b1;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d ticks scored across %0d register writes, thresholds 0 to 40",
             n_ticks, n_writes);
    $display("%0d results carried debounced flags, %0d carried a stop", n_flagged, n_stopped);
    if (mism == 0 && guard_due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
